// File: rtl/core/fsb_pkg.sv
package fsb_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 64;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int ROW_W    = $clog2(MAX_HEIGHT);
  localparam int PIX_W    = 8;
  localparam int WIDTH_W  = 8;
  localparam int HEIGHT_W = 7;
  localparam int ERR_W    = 10;

  localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(MAX_HEIGHT);

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 8'd128;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 7'd64;
  localparam logic [PIX_W-1:0]    THRESH_RST = 8'd124;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_THRESH = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [ERR_W-1:0] data;
  } fsb_wr_t;

  typedef struct packed {
    logic             pixel_on;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic             frame_last;
  } fsb_res_t;

endpackage

// File: rtl/core/fsb_line_buf.sv
module fsb_line_buf
  import fsb_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  fsb_wr_t          wr_i,
  output logic [ERR_W-1:0] rd_data_o
);

  logic [ERR_W-1:0]     mem_q [MAX_WIDTH];
  logic [MAX_WIDTH-1:0] vld_q;
  logic [ERR_W-1:0]     rd_data_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// File: rtl/core/fsb_out_q.sv
module fsb_out_q
  import fsb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  fsb_res_t   data_i,
  input  logic       pop_i,
  output logic       valid_o,
  output fsb_res_t   data_o,
  output logic [1:0] count_o
);

  fsb_res_t   slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assign valid_o = (count_q != 2'd0);
  assign data_o  = slot_q[rd_ptr_q];
  assign count_o = count_q;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |-> (count_q != 2'd2))
    else $error("output queue overflow");
`endif

endmodule

// File: rtl/core/floyd_steinberg_binarizer_unit.sv
// One-bit Floyd-Steinberg binarizer: takes one gray pixel per clock in raster order while
// in_stall_o is low and returns one request per pixel with the lit bit, its column and
// row, and a flag on the last pixel of the image. An accepted pixel is registered in the
// buffer stage and its result is then pushed into the two-entry output queue, which
// raises out_valid_o. The sustained rate is one pixel per clock while out_stall_i is low.
// That rate is set by the single write port of the 128-entry error line buffer (the
// extra row-end write goes out in the slot of the next row's first pixel, which writes
// nothing) and by the registered loop that carries the right-hand error share to the
// next pixel. Per-entry valid bits make the buffer read as zero from reset, so no
// clearing pass is needed. The user must write width, height and threshold through the
// cfg port only while no pixel is in flight; the block does not enforce this.
module floyd_steinberg_binarizer_unit
  import fsb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [PIX_W-1:0]    gray_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                pixel_on_o,
  output logic [COL_W-1:0]    column_o,
  output logic [ROW_W-1:0]    row_o,
  output logic                frame_last_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [WIDTH_W-1:0]  cfg_data_i
);

  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [PIX_W-1:0]    thresh_q;

  logic [COL_W-1:0] col_cnt_q, col_cnt_d;
  logic [ROW_W-1:0] row_cnt_q, row_cnt_d;

  logic                accept;
  logic                pop;
  logic [1:0]          q_count;
  logic [2:0]          occ;
  logic [WIDTH_W-1:0]  ew;
  logic [HEIGHT_W-1:0] eh;
  logic [COL_W-1:0]    col_a;
  logic [ROW_W-1:0]    row_a;
  logic                last_col_a, last_row_a;

  logic             b_valid_q;
  logic [PIX_W-1:0] b_gray_q;
  logic [COL_W-1:0] b_col_q;
  logic [ROW_W-1:0] b_row_q;
  logic             b_last_col_q, b_last_row_q;

  logic signed [7:0]       right_carry_q, right_carry_d;
  logic signed [7:0]       pend_here_q, pend_here_d;
  logic signed [4:0]       pend_right_q, pend_right_d;

  fsb_wr_t          hold_q, hold_d;
  fsb_wr_t          fwd_q;
  fsb_wr_t          b_wr;
  fsb_wr_t          mem_wr;
  logic [ERR_W-1:0] rd_data;

  logic                    b_col_zero;
  logic signed [7:0]       left;
  logic signed [4:0]       pr;
  logic signed [ERR_W-1:0] above;
  logic signed [10:0]      sum;
  logic [PIX_W-1:0]        val;
  logic                    on;
  logic signed [8:0]       err;
  logic signed [11:0]      e_x, e3, e5, e7;
  logic signed [7:0]       s3, s5, s7;
  logic signed [4:0]       s1;
  logic signed [7:0]       ph_new;
  logic signed [ERR_W-1:0] ph_new_x;
  logic signed [ERR_W-1:0] left_entry;
  fsb_res_t                res;
  fsb_res_t                q_data;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      thresh_q <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_WIDTH:  width_q  <= cfg_data_i;
        CFG_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        CFG_THRESH: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // flow control: room for the pixel now in the buffer stage plus a new one
  assign pop        = out_valid_o && !out_stall_i;
  assign occ        = {1'b0, q_count} + {2'b0, b_valid_q} - {2'b0, pop};
  assign in_stall_o = (occ >= 3'd2);
  assign accept     = in_valid_i && !in_stall_o;

  // position of the incoming pixel
  always_comb begin
    if (width_q == '0) begin
      ew = WIDTH_W'(1);
    end else if (width_q > WIDTH_MAX) begin
      ew = WIDTH_MAX;
    end else begin
      ew = width_q;
    end
    if (height_q == '0) begin
      eh = HEIGHT_W'(1);
    end else if (height_q > HEIGHT_MAX) begin
      eh = HEIGHT_MAX;
    end else begin
      eh = height_q;
    end
    col_a = ({1'b0, col_cnt_q} >= ew) ? COL_W'(ew - WIDTH_W'(1)) : col_cnt_q;
    row_a = ({1'b0, row_cnt_q} >= eh) ? ROW_W'(eh - HEIGHT_W'(1)) : row_cnt_q;
    last_col_a = ({1'b0, col_a} == (ew - WIDTH_W'(1)));
    last_row_a = ({1'b0, row_a} == (eh - HEIGHT_W'(1)));
    if (last_col_a) begin
      col_cnt_d = '0;
      row_cnt_d = last_row_a ? '0 : row_a + ROW_W'(1);
    end else begin
      col_cnt_d = col_a + COL_W'(1);
      row_cnt_d = row_a;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      b_valid_q <= 1'b0;
    end else begin
      b_valid_q <= accept;
      if (accept) begin
        col_cnt_q <= col_cnt_d;
        row_cnt_q <= row_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_gray_q     <= gray_i;
      b_col_q      <= col_a;
      b_row_q      <= row_a;
      b_last_col_q <= last_col_a;
      b_last_row_q <= last_row_a;
    end
  end

  // quantize and diffuse
  always_comb begin
    b_col_zero = (b_col_q == '0);
    left       = b_col_zero ? 8'sd0 : right_carry_q;
    pr         = b_col_zero ? 5'sd0 : pend_right_q;

    if (b_row_q == '0) begin
      above = '0;
    end else if (hold_q.en && (hold_q.addr == b_col_q)) begin
      above = $signed(hold_q.data);
    end else if (fwd_q.en && (fwd_q.addr == b_col_q)) begin
      above = $signed(fwd_q.data);
    end else begin
      above = $signed(rd_data);
    end

    sum = $signed({3'b000, b_gray_q}) + $signed({{3{left[7]}}, left})
        + $signed({above[ERR_W-1], above});
    if (sum < 11'sd0) begin
      val = '0;
    end else if (sum > 11'sd255) begin
      val = 8'd255;
    end else begin
      val = sum[7:0];
    end
    on  = (val > thresh_q);
    err = on ? ($signed({1'b0, val}) - 9'sd255) : $signed({1'b0, val});

    e_x = $signed({{3{err[8]}}, err});
    e3  = (e_x <<< 1) + e_x;
    e5  = (e_x <<< 2) + e_x;
    e7  = (e_x <<< 3) - e_x;
    s3  = e3[11:4];
    s5  = e5[11:4];
    s7  = e7[11:4];
    s1  = err[8:4];

    ph_new     = $signed({{3{pr[4]}}, pr}) + s5;
    ph_new_x   = $signed({{2{ph_new[7]}}, ph_new});
    left_entry = $signed({{2{pend_here_q[7]}}, pend_here_q})
               + $signed({{2{s3[7]}}, s3});

    b_wr   = '0;
    hold_d = '0;
    if (b_valid_q) begin
      if (!b_col_zero) begin
        b_wr.en   = 1'b1;
        b_wr.addr = b_col_q - COL_W'(1);
        b_wr.data = left_entry;
        if (b_last_col_q) begin
          hold_d.en   = 1'b1;
          hold_d.addr = b_col_q;
          hold_d.data = ph_new_x;
        end
      end else if (b_last_col_q) begin
        b_wr.en   = 1'b1;
        b_wr.addr = b_col_q;
        b_wr.data = ph_new_x;
      end
    end

    mem_wr = hold_q.en ? hold_q : b_wr;

    right_carry_d = right_carry_q;
    pend_here_d   = pend_here_q;
    pend_right_d  = pend_right_q;
    if (b_valid_q) begin
      if (b_last_col_q) begin
        right_carry_d = '0;
        pend_here_d   = '0;
        pend_right_d  = '0;
      end else begin
        right_carry_d = s7;
        pend_here_d   = ph_new;
        pend_right_d  = s1;
      end
    end

    res.pixel_on   = on;
    res.column     = b_col_q;
    res.row        = b_row_q;
    res.frame_last = b_last_col_q && b_last_row_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_carry_q <= '0;
      pend_here_q   <= '0;
      pend_right_q  <= '0;
      hold_q        <= '0;
      fwd_q         <= '0;
    end else begin
      right_carry_q <= right_carry_d;
      pend_here_q   <= pend_here_d;
      pend_right_q  <= pend_right_d;
      hold_q        <= hold_d;
      fwd_q         <= mem_wr;
    end
  end

  fsb_line_buf u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (col_a),
    .wr_i      (mem_wr),
    .rd_data_o (rd_data)
  );

  fsb_out_q u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (b_valid_q),
    .data_i  (res),
    .pop_i   (pop),
    .valid_o (out_valid_o),
    .data_o  (q_data),
    .count_o (q_count)
  );

  assign pixel_on_o   = q_data.pixel_on;
  assign column_o     = q_data.column;
  assign row_o        = q_data.row;
  assign frame_last_o = q_data.frame_last;

`ifndef NO_ASSERTIONS
  a_single_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q.en |-> !b_wr.en)
    else $error("deferred row-end write collides with a pixel write");

  a_hold_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_q.en |-> $past(b_valid_q && b_last_col_q))
    else $error("deferred write without a row-end pixel");

  a_accept_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (b_valid_q && (q_count != 2'd2 || $past(pop))))
    else $error("accepted pixel has no room downstream");
`endif

endmodule
